// File: rtl/shle_pkg.sv
// shared types, constants and sequencer codes for the spherical-harmonic lighting block
package shle_pkg;

  localparam int COEFF_WIDTH_DEF = 16;
  localparam int DIR_WIDTH_DEF   = 16;

  localparam int TERMS       = 16;
  localparam int TERM_W      = 4;
  localparam int NUM_COLOURS = 3;
  localparam int CH_W        = 2;
  localparam int BASIS_FRAC  = 15;
  localparam int BASIS_W     = 20;
  localparam int OUT_W       = 16;
  localparam int CNT_W       = 5;

  localparam logic [CNT_W-1:0] PROD_LAST = 5'd16;
  localparam logic [CNT_W-1:0] MAC_LAST  = 5'd17;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_EVAL  = 1'b1;

  // product slots of the shared multiplier, in issue order
  localparam logic [TERM_W-1:0] SL_XX  = 4'd0;
  localparam logic [TERM_W-1:0] SL_YY  = 4'd1;
  localparam logic [TERM_W-1:0] SL_ZZ  = 4'd2;
  localparam logic [TERM_W-1:0] SL_XY  = 4'd3;
  localparam logic [TERM_W-1:0] SL_YZ  = 4'd4;
  localparam logic [TERM_W-1:0] SL_ZX  = 4'd5;
  localparam logic [TERM_W-1:0] SL_XXY = 4'd6;
  localparam logic [TERM_W-1:0] SL_YYY = 4'd7;
  localparam logic [TERM_W-1:0] SL_XYZ = 4'd8;
  localparam logic [TERM_W-1:0] SL_ZZY = 4'd9;
  localparam logic [TERM_W-1:0] SL_ZZZ = 4'd10;
  localparam logic [TERM_W-1:0] SL_ZZX = 4'd11;
  localparam logic [TERM_W-1:0] SL_XXZ = 4'd12;
  localparam logic [TERM_W-1:0] SL_YYZ = 4'd13;
  localparam logic [TERM_W-1:0] SL_XXX = 4'd14;
  localparam logic [TERM_W-1:0] SL_YYX = 4'd15;

  // basis terms, index l*(l+1)+m
  localparam logic [TERM_W-1:0] BT_ONE    = 4'd0;
  localparam logic [TERM_W-1:0] BT_Y      = 4'd1;
  localparam logic [TERM_W-1:0] BT_Z      = 4'd2;
  localparam logic [TERM_W-1:0] BT_X      = 4'd3;
  localparam logic [TERM_W-1:0] BT_XY     = 4'd4;
  localparam logic [TERM_W-1:0] BT_YZ     = 4'd5;
  localparam logic [TERM_W-1:0] BT_Z2     = 4'd6;
  localparam logic [TERM_W-1:0] BT_ZX     = 4'd7;
  localparam logic [TERM_W-1:0] BT_X2Y2   = 4'd8;
  localparam logic [TERM_W-1:0] BT_Y3     = 4'd9;
  localparam logic [TERM_W-1:0] BT_XYZ    = 4'd10;
  localparam logic [TERM_W-1:0] BT_YZ2    = 4'd11;
  localparam logic [TERM_W-1:0] BT_Z3     = 4'd12;
  localparam logic [TERM_W-1:0] BT_XZ2    = 4'd13;
  localparam logic [TERM_W-1:0] BT_ZX2Y2  = 4'd14;
  localparam logic [TERM_W-1:0] BT_X3     = 4'd15;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROD,
    ST_MAC,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic             load_dir;
    logic             prod_run;
    logic             mac_run;
    logic [CNT_W-1:0] cnt;
  } seq_ctrl_t;

endpackage

// File: rtl/sh_lighting_eval_rgb.sv
// top level: four-band spherical-harmonic lighting evaluation for red, green and blue
//
//   channel  | handshake                | words
//   ---------+--------------------------+------------------------------------------------
//   input    | in_valid_i / in_stall_o  | kind, channel, coeff_index, coeff_value, dir_*
//   output   | out_valid_o / out_stall_i| red, green, blue
//
// a coefficient write is taken and gives no result
// an evaluate result is registered after a product pass on the shared product multiplier,
// an accumulation pass in the colour lanes reading and accumulating the 16 terms, and a
// final step to round, clamp and load
// the input stalls while an evaluate word is in flight; a waiting result holds only the load
// reset clears the coefficient valid flags and all control state at once
module sh_lighting_eval_rgb #(
  parameter int COEFF_WIDTH = shle_pkg::COEFF_WIDTH_DEF,
  parameter int DIR_WIDTH   = shle_pkg::DIR_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              kind_i,
  input  logic [shle_pkg::CH_W-1:0]         channel_i,
  input  logic [shle_pkg::TERM_W-1:0]       coeff_index_i,
  input  logic signed [COEFF_WIDTH-1:0]     coeff_value_i,
  input  logic signed [DIR_WIDTH-1:0]       dir_x_i,
  input  logic signed [DIR_WIDTH-1:0]       dir_y_i,
  input  logic signed [DIR_WIDTH-1:0]       dir_z_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [shle_pkg::OUT_W-1:0]        red_o,
  output logic [shle_pkg::OUT_W-1:0]        green_o,
  output logic [shle_pkg::OUT_W-1:0]        blue_o
);
  import shle_pkg::*;

  state_e                      state_q, state_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  seq_ctrl_t                   ctrl;
  logic                        in_acc, coef_wr, out_load;
  logic                        out_valid_q;
  logic [OUT_W-1:0]            red_q, green_q, blue_q;
  logic signed [BASIS_W-1:0]   basis;
  logic signed [COEFF_WIDTH-1:0] coef [NUM_COLOURS];
  logic [OUT_W-1:0]            res  [NUM_COLOURS];

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (kind_i == KIND_EVAL)) begin
          state_d = ST_PROD;
          cnt_d   = '0;
        end
      end
      ST_PROD: begin
        if (cnt_q == PROD_LAST) begin
          state_d = ST_MAC;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_MAC: begin
        if (cnt_q == MAC_LAST) begin
          state_d = ST_FIN;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o    = (state_q != ST_IDLE);
    in_acc        = in_valid_i && !in_stall_o;
    coef_wr       = in_acc && (kind_i == KIND_WRITE);
    ctrl.load_dir = in_acc && (kind_i == KIND_EVAL);
    ctrl.prod_run = (state_q == ST_PROD);
    ctrl.mac_run  = (state_q == ST_MAC);
    ctrl.cnt      = cnt_q;
    out_load      = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  shle_coef_store #(
    .COEFF_WIDTH (COEFF_WIDTH)
  ) u_coef_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (coef_wr),
    .wr_channel_i (channel_i),
    .wr_index_i   (coeff_index_i),
    .wr_value_i   (coeff_value_i),
    .rd_index_i   (cnt_q[TERM_W-1:0]),
    .coef_o       (coef)
  );

  shle_basis_unit #(
    .DIR_WIDTH (DIR_WIDTH)
  ) u_basis_unit (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .dir_x_i (dir_x_i),
    .dir_y_i (dir_y_i),
    .dir_z_i (dir_z_i),
    .basis_o (basis)
  );

  shle_mac #(
    .COEFF_WIDTH (COEFF_WIDTH)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .basis_i (basis),
    .coef_i  (coef),
    .res_o   (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      red_q   <= res[0];
      green_q <= res[1];
      blue_q  <= res[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

  a_mac_after_prod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC && cnt_q == '0) |-> ($past(state_q) == ST_PROD))
    else $error("accumulation started without a product pass");

  a_fin_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && !out_valid_q) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("finished word not moved to a free output register");

  a_prod_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROD) |-> (cnt_q <= PROD_LAST))
    else $error("product step counter overran");

  a_mac_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC) |-> (cnt_q <= MAC_LAST))
    else $error("accumulate step counter overran");

endmodule

// File: rtl/shle_coef_store.sv
// coefficient table: 16 signed terms for each of red, green and blue
module shle_coef_store #(
  parameter int COEFF_WIDTH = shle_pkg::COEFF_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                wr_en_i,
  input  logic [shle_pkg::CH_W-1:0]           wr_channel_i,
  input  logic [shle_pkg::TERM_W-1:0]         wr_index_i,
  input  logic signed [COEFF_WIDTH-1:0]       wr_value_i,
  input  logic [shle_pkg::TERM_W-1:0]         rd_index_i,
  output logic signed [COEFF_WIDTH-1:0]       coef_o [shle_pkg::NUM_COLOURS]
);
  import shle_pkg::*;

  // one memory per colour, read data registered; channel three matches no colour and is dropped
  for (genvar c = 0; c < NUM_COLOURS; c++) begin : g_colour
    logic signed [COEFF_WIDTH-1:0] mem_q [TERMS];
    logic [TERMS-1:0]              vld_q;
    logic signed [COEFF_WIDTH-1:0] rd_q;
    logic                          rd_vld_q;
    logic                          wr_hit;

    assign wr_hit = wr_en_i && (wr_channel_i == CH_W'(c));

    // entries not written since reset read as zero
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q    <= '0;
        rd_vld_q <= 1'b0;
      end else begin
        if (wr_hit) begin
          vld_q[wr_index_i] <= 1'b1;
        end
        rd_vld_q <= vld_q[rd_index_i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (wr_hit) begin
        mem_q[wr_index_i] <= wr_value_i;
      end
      rd_q <= mem_q[rd_index_i];
    end

    assign coef_o[c] = rd_vld_q ? rd_q : '0;
  end

endmodule

// File: rtl/shle_basis_unit.sv
// shared multiplier building the polynomial products, and basis term selection
module shle_basis_unit #(
  parameter int DIR_WIDTH = shle_pkg::DIR_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  shle_pkg::seq_ctrl_t                    ctrl_i,
  input  logic signed [DIR_WIDTH-1:0]            dir_x_i,
  input  logic signed [DIR_WIDTH-1:0]            dir_y_i,
  input  logic signed [DIR_WIDTH-1:0]            dir_z_i,
  output logic signed [shle_pkg::BASIS_W-1:0]    basis_o
);
  import shle_pkg::*;

  localparam int F  = DIR_WIDTH - 1;
  localparam int W1 = DIR_WIDTH + 1;
  localparam int PW = 2 * W1;
  localparam int BW = DIR_WIDTH + 4;

  localparam logic signed [PW-1:0] P_HALF = PW'(1) << (F - 1);
  localparam logic signed [BW-1:0] ONE_B  = BW'(1) << F;

  logic signed [DIR_WIDTH-1:0] dx_q, dy_q, dz_q;
  logic signed [PW-1:0]        raw_q;
  logic signed [W1-1:0]        p_q [TERMS];

  logic signed [W1-1:0]  ex, ey, ez;
  logic signed [W1-1:0]  op_a, op_b;
  logic [TERM_W-1:0]     step;
  logic [TERM_W-1:0]     wr_slot;
  logic                  issue, wr_en;
  logic signed [PW-1:0]  rnd_p, rnd_sh;
  logic signed [BW-1:0]  bx, by, bz;
  logic signed [BW-1:0]  bp [TERMS];
  logic signed [BW-1:0]  term;

  assign step    = ctrl_i.cnt[TERM_W-1:0];
  assign wr_slot = TERM_W'(ctrl_i.cnt - CNT_W'(1));
  assign issue   = ctrl_i.prod_run && (ctrl_i.cnt < CNT_W'(TERMS));
  assign wr_en   = ctrl_i.prod_run && (ctrl_i.cnt != '0);

  assign ex = W1'(dx_q);
  assign ey = W1'(dy_q);
  assign ez = W1'(dz_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_dir) begin
      dx_q <= dir_x_i;
      dy_q <= dir_y_i;
      dz_q <= dir_z_i;
    end
  end

  // operand pairs: plain squares and cross terms first, cubic terms from stored squares and the stored xy product
  always_comb begin
    op_a = ex;
    op_b = ex;
    case (step)
      SL_XX:   begin op_a = ex;        op_b = ex; end
      SL_YY:   begin op_a = ey;        op_b = ey; end
      SL_ZZ:   begin op_a = ez;        op_b = ez; end
      SL_XY:   begin op_a = ex;        op_b = ey; end
      SL_YZ:   begin op_a = ey;        op_b = ez; end
      SL_ZX:   begin op_a = ez;        op_b = ex; end
      SL_XXY:  begin op_a = p_q[SL_XX]; op_b = ey; end
      SL_YYY:  begin op_a = p_q[SL_YY]; op_b = ey; end
      SL_XYZ:  begin op_a = p_q[SL_XY]; op_b = ez; end
      SL_ZZY:  begin op_a = p_q[SL_ZZ]; op_b = ey; end
      SL_ZZZ:  begin op_a = p_q[SL_ZZ]; op_b = ez; end
      SL_ZZX:  begin op_a = p_q[SL_ZZ]; op_b = ex; end
      SL_XXZ:  begin op_a = p_q[SL_XX]; op_b = ez; end
      SL_YYZ:  begin op_a = p_q[SL_YY]; op_b = ez; end
      SL_XXX:  begin op_a = p_q[SL_XX]; op_b = ex; end
      SL_YYX:  begin op_a = p_q[SL_YY]; op_b = ex; end
      default: begin op_a = ex;        op_b = ex; end
    endcase
  end

  // round half up back to the direction format; magnitude never exceeds one
  assign rnd_p  = raw_q + P_HALF;
  assign rnd_sh = rnd_p >>> F;

  always_ff @(posedge clk_i) begin
    if (issue) begin
      raw_q <= op_a * op_b;
    end
    if (wr_en) begin
      p_q[wr_slot] <= rnd_sh[W1-1:0];
    end
  end

  assign bx = BW'(dx_q);
  assign by = BW'(dy_q);
  assign bz = BW'(dz_q);

  always_comb begin
    for (int i = 0; i < TERMS; i++) begin
      bp[i] = BW'(p_q[i]);
    end
  end

  always_comb begin
    term = ONE_B;
    case (step)
      BT_ONE:   term = ONE_B;
      BT_Y:     term = by;
      BT_Z:     term = bz;
      BT_X:     term = bx;
      BT_XY:    term = bp[SL_XY];
      BT_YZ:    term = bp[SL_YZ];
      BT_Z2:    term = (bp[SL_ZZ] <<< 1) + bp[SL_ZZ] - ONE_B;
      BT_ZX:    term = bp[SL_ZX];
      BT_X2Y2:  term = bp[SL_XX] - bp[SL_YY];
      BT_Y3:    term = (bp[SL_XXY] <<< 1) + bp[SL_XXY] - bp[SL_YYY];
      BT_XYZ:   term = bp[SL_XYZ];
      BT_YZ2:   term = (bp[SL_ZZY] <<< 2) + bp[SL_ZZY] - by;
      BT_Z3:    term = (bp[SL_ZZZ] <<< 2) + bp[SL_ZZZ] - ((bz <<< 1) + bz);
      BT_XZ2:   term = (bp[SL_ZZX] <<< 2) + bp[SL_ZZX] - bx;
      BT_ZX2Y2: term = bp[SL_XXZ] - bp[SL_YYZ];
      BT_X3:    term = bp[SL_XXX] - ((bp[SL_YYX] <<< 1) + bp[SL_YYX]);
      default:  term = ONE_B;
    endcase
  end

  // bring the term to fifteen fraction bits
  generate
    if (F > BASIS_FRAC) begin : g_down
      localparam int SH = F - BASIS_FRAC;
      localparam logic signed [BW-1:0] B_HALF = BW'(1) << (SH - 1);
      logic signed [BW-1:0] rnd_b, sh_b;
      assign rnd_b   = term + B_HALF;
      assign sh_b    = rnd_b >>> SH;
      assign basis_o = BASIS_W'(sh_b);
    end else if (F < BASIS_FRAC) begin : g_up
      assign basis_o = BASIS_W'(term) <<< (BASIS_FRAC - F);
    end else begin : g_same
      assign basis_o = BASIS_W'(term);
    end
  endgenerate

endmodule

// File: rtl/shle_mac.sv
// three multiply-accumulate lanes, one per colour, with rounding and clamping
module shle_mac #(
  parameter int COEFF_WIDTH = shle_pkg::COEFF_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  shle_pkg::seq_ctrl_t                  ctrl_i,
  input  logic signed [shle_pkg::BASIS_W-1:0]  basis_i,
  input  logic signed [COEFF_WIDTH-1:0]        coef_i [shle_pkg::NUM_COLOURS],
  output logic [shle_pkg::OUT_W-1:0]           res_o  [shle_pkg::NUM_COLOURS]
);
  import shle_pkg::*;

  localparam int PRW   = COEFF_WIDTH + BASIS_W;
  localparam int ACC_W = PRW + TERM_W;

  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (BASIS_FRAC - 1);

  logic                        s1v_q, s2v_q;
  logic signed [BASIS_W-1:0]   basis_q;
  logic signed [PRW-1:0]       prod_q [NUM_COLOURS];
  logic signed [ACC_W-1:0]     acc_q  [NUM_COLOURS];
  logic signed [ACC_W-1:0]     rnd    [NUM_COLOURS];
  logic signed [ACC_W-1:0]     sh     [NUM_COLOURS];
  logic                        s1;

  assign s1 = ctrl_i.mac_run && (ctrl_i.cnt < CNT_W'(TERMS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1v_q <= 1'b0;
      s2v_q <= 1'b0;
    end else begin
      s1v_q <= s1;
      s2v_q <= s1v_q;
    end
  end

  // fetch, multiply and accumulate stages; the coefficient arrives from the table's read register
  always_ff @(posedge clk_i) begin
    if (s1) begin
      basis_q <= basis_i;
    end
    if (s1v_q) begin
      for (int c = 0; c < NUM_COLOURS; c++) begin
        prod_q[c] <= coef_i[c] * basis_q;
      end
    end
    for (int c = 0; c < NUM_COLOURS; c++) begin
      if (ctrl_i.load_dir) begin
        acc_q[c] <= '0;
      end else if (s2v_q) begin
        acc_q[c] <= acc_q[c] + ACC_W'(prod_q[c]);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_COLOURS; c++) begin
      rnd[c] = acc_q[c] + ACC_HALF;
      sh[c]  = rnd[c] >>> BASIS_FRAC;
      if (sh[c][ACC_W-1]) begin
        res_o[c] = '0;
      end else if (|sh[c][ACC_W-2:OUT_W]) begin
        res_o[c] = '1;
      end else begin
        res_o[c] = sh[c][OUT_W-1:0];
      end
    end
  end

endmodule

// File: sim/sh_lighting_eval_rgb_test.sv
// self-checking testbench for the spherical-harmonic lighting block: table-driven start, then random words
`timescale 1ns / 100ps

module sh_lighting_eval_rgb_test;
  import shle_pkg::*;

  localparam int DIR_FRAC = DIR_WIDTH_DEF - 1;
  localparam longint HALF_LSB = 64'sd1 <<< (DIR_FRAC - 1);
  localparam int RANDOM_WORDS = 1200;
  localparam int DRAIN_CYCLES = 60;

  localparam logic [CH_W-1:0] CH_RED   = 2'd0;
  localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
  localparam logic [CH_W-1:0] CH_BLUE  = 2'd2;
  localparam logic [CH_W-1:0] CH_NONE  = 2'd3;

  typedef struct packed {
    logic [OUT_W-1:0] red;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic                     kind;
    logic [CH_W-1:0]          channel;
    logic [TERM_W-1:0]        coeff_idx;
    logic [COEFF_WIDTH_DEF-1:0] coeff;
    logic [DIR_WIDTH_DEF-1:0] x;
    logic [DIR_WIDTH_DEF-1:0] y;
    logic [DIR_WIDTH_DEF-1:0] z;
    logic                     typed;
    rgb_t                     rgb;
  } stim_t;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic                              kind_i;
  logic [CH_W-1:0]                   channel_i;
  logic [TERM_W-1:0]                 coeff_index_i;
  logic signed [COEFF_WIDTH_DEF-1:0] coeff_value_i;
  logic signed [DIR_WIDTH_DEF-1:0]   dir_x_i;
  logic signed [DIR_WIDTH_DEF-1:0]   dir_y_i;
  logic signed [DIR_WIDTH_DEF-1:0]   dir_z_i;
  logic                              out_valid_o;
  logic                              out_stall_i;
  logic [OUT_W-1:0]                  red_o;
  logic [OUT_W-1:0]                  green_o;
  logic [OUT_W-1:0]                  blue_o;

  // expectation typed into the table, travelling with the word being driven
  logic typed_on;
  rgb_t typed_rgb;
  logic calm;
  int   stall_hold;

  logic signed [COEFF_WIDTH_DEF-1:0] coeff_store [NUM_COLOURS*TERMS];
  rgb_t  pending_rgb [$];
  stim_t directed_words [$];
  int    mismatches;

  sh_lighting_eval_rgb dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .channel_i     (channel_i),
    .coeff_index_i (coeff_index_i),
    .coeff_value_i (coeff_value_i),
    .dir_x_i       (dir_x_i),
    .dir_y_i       (dir_y_i),
    .dir_z_i       (dir_z_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic longint fix_mul(input longint a, input longint b);
    return (a * b + HALF_LSB) >>> DIR_FRAC;
  endfunction

  function automatic rgb_t radiance_of(input logic signed [DIR_WIDTH_DEF-1:0] dx,
                                       input logic signed [DIR_WIDTH_DEF-1:0] dy,
                                       input logic signed [DIR_WIDTH_DEF-1:0] dz);
    longint x, y, z, xx, yy, zz, xy, yz, zx, one, acc, level;
    longint b [TERMS];
    logic [OUT_W-1:0] lit [NUM_COLOURS];
    rgb_t res;
    x = dx;
    y = dy;
    z = dz;
    one = 64'sd1 <<< DIR_FRAC;
    xx = fix_mul(x, x);
    yy = fix_mul(y, y);
    zz = fix_mul(z, z);
    xy = fix_mul(x, y);
    yz = fix_mul(y, z);
    zx = fix_mul(z, x);
    b[BT_ONE]   = one;
    b[BT_Y]     = y;
    b[BT_Z]     = z;
    b[BT_X]     = x;
    b[BT_XY]    = xy;
    b[BT_YZ]    = yz;
    b[BT_Z2]    = 3 * zz - one;
    b[BT_ZX]    = zx;
    b[BT_X2Y2]  = xx - yy;
    b[BT_Y3]    = 3 * fix_mul(xx, y) - fix_mul(yy, y);
    b[BT_XYZ]   = fix_mul(xy, z);
    b[BT_YZ2]   = 5 * fix_mul(zz, y) - y;
    b[BT_Z3]    = 5 * fix_mul(zz, z) - 3 * z;
    b[BT_XZ2]   = 5 * fix_mul(zz, x) - x;
    b[BT_ZX2Y2] = fix_mul(xx, z) - fix_mul(yy, z);
    b[BT_X3]    = fix_mul(xx, x) - 3 * fix_mul(yy, x);
    // direction fraction matches the basis fraction, so the terms are used as they are
    for (int c = 0; c < NUM_COLOURS; c++) begin
      acc = 0;
      for (int i = 0; i < TERMS; i++)
        acc += longint'(coeff_store[c*TERMS + i]) * b[i];
      level = (acc + (64'sd1 <<< (BASIS_FRAC - 1))) >>> BASIS_FRAC;
      if (level < 0)
        lit[c] = '0;
      else if (level > 65535)
        lit[c] = '1;
      else
        lit[c] = OUT_W'(level);
    end
    res.red   = lit[0];
    res.green = lit[1];
    res.blue  = lit[2];
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic stim_t write_word(input logic [CH_W-1:0] ch,
                                       input logic [TERM_W-1:0] idx,
                                       input logic [COEFF_WIDTH_DEF-1:0] val);
    stim_t s;
    s = '0;
    s.kind = KIND_WRITE;
    s.channel = ch;
    s.coeff_idx = idx;
    s.coeff = val;
    return s;
  endfunction

  function automatic stim_t eval_word(input logic [DIR_WIDTH_DEF-1:0] x,
                                      input logic [DIR_WIDTH_DEF-1:0] y,
                                      input logic [DIR_WIDTH_DEF-1:0] z);
    stim_t s;
    s = '0;
    s.kind = KIND_EVAL;
    s.x = x;
    s.y = y;
    s.z = z;
    return s;
  endfunction

  function automatic stim_t eval_known(input logic [DIR_WIDTH_DEF-1:0] x,
                                       input logic [DIR_WIDTH_DEF-1:0] y,
                                       input logic [DIR_WIDTH_DEF-1:0] z,
                                       input logic [OUT_W-1:0] r,
                                       input logic [OUT_W-1:0] g,
                                       input logic [OUT_W-1:0] bl);
    stim_t s;
    s = eval_word(x, y, z);
    s.typed = 1'b1;
    s.rgb = '{r, g, bl};
    return s;
  endfunction

  function automatic logic [DIR_WIDTH_DEF-1:0] random_dir();
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 6))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          3: return 16'hFFFF;
          4: return 16'h0001;
          5: return 16'hC000;
          default: return 16'h4000;
        endcase
      end
      // each component within about plus or minus 1/sqrt(2)
      1: return 16'($urandom_range(0, 46340) - 23170);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [COEFF_WIDTH_DEF-1:0] random_coeff();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6)
      return 16'($urandom_range(0, 8192) - 4096);
    if (r < 9)
      return 16'($urandom);
    case ($urandom_range(0, 3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      default: return 16'h0001;
    endcase
  endfunction

  function automatic stim_t random_word();
    stim_t s;
    int r;
    r = $urandom_range(0, 99);
    // garbage in the unused fields of every word
    s.channel   = 2'($urandom);
    s.coeff_idx = 4'($urandom);
    s.coeff     = 16'($urandom);
    s.x         = 16'($urandom);
    s.y         = 16'($urandom);
    s.z         = 16'($urandom);
    s.typed     = 1'b0;
    s.rgb       = '0;
    if (r < 50) begin
      s.kind = KIND_WRITE;
      s.channel = ($urandom_range(0, 9) == 0) ? CH_NONE : 2'($urandom_range(0, 2));
      s.coeff = random_coeff();
    end else if (r < 95) begin
      s.kind = KIND_EVAL;
      s.x = random_dir();
      s.y = random_dir();
      s.z = random_dir();
    end else begin
      s.kind = 1'($urandom);
    end
    return s;
  endfunction

  // appends one word to the directed table
  task automatic queue_word(input stim_t s);
    directed_words.insert(directed_words.size(), s);
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send(input stim_t s);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= s.kind;
    channel_i     <= s.channel;
    coeff_index_i <= s.coeff_idx;
    coeff_value_i <= s.coeff;
    dir_x_i       <= s.x;
    dir_y_i       <= s.y;
    dir_z_i       <= s.z;
    typed_on      <= s.typed;
    typed_rgb     <= s.rgb;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_rgb.size() != 0) @(negedge clk_i);
  endtask

  // receiver stall, held for random stretches
  always @(negedge clk_i) begin
    if (!rst_ni || calm) begin
      out_stall_i <= 1'b0;
      stall_hold  <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 3) == 0);
      stall_hold  <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    rgb_t want;
    rgb_t got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (kind_i == KIND_WRITE) begin
          // a write to the unused channel is dropped
          if (channel_i != CH_NONE)
            coeff_store[int'(channel_i)*TERMS + int'(coeff_index_i)] = coeff_value_i;
        end else begin
          want = typed_on ? typed_rgb : radiance_of(dir_x_i, dir_y_i, dir_z_i);
          pending_rgb.insert(pending_rgb.size(), want);
        end
      end
      if (out_valid_o && !out_stall_i) begin
        got = '{red_o, green_o, blue_o};
        if (pending_rgb.size() == 0) begin
          $error("unexpected result word: red %0d green %0d blue %0d", red_o, green_o, blue_o);
          mismatches++;
        end else begin
          want = pending_rgb.pop_front();
          if (got.red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, got.red);
            mismatches++;
          end
          if (got.green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, got.green);
            mismatches++;
          end
          if (got.blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, got.blue);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    int guard;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    kind_i        = KIND_WRITE;
    channel_i     = CH_RED;
    coeff_index_i = BT_ONE;
    coeff_value_i = '0;
    dir_x_i       = '0;
    dir_y_i       = '0;
    dir_z_i       = '0;
    out_stall_i   = 1'b0;
    typed_on      = 1'b0;
    typed_rgb     = '0;
    calm          = 1'b0;
    stall_hold    = 0;
    mismatches    = 0;
    for (int i = 0; i < NUM_COLOURS*TERMS; i++)
      coeff_store[i] = '0;

    queue_word(eval_known(16'h0000, 16'h0000, 16'h0000, 0, 0, 0));
    queue_word(eval_known(16'h8000, 16'h7FFF, 16'h8000, 0, 0, 0));
    queue_word(write_word(CH_RED, BT_ONE, 16'd4096));
    queue_word(write_word(CH_NONE, BT_ONE, 16'hFFFF));
    queue_word(write_word(CH_NONE, BT_Z3, 16'h7FFF));
    queue_word(eval_known(16'h0000, 16'h0000, 16'h0000, 4096, 0, 0));
    queue_word(write_word(CH_GREEN, BT_ONE, 16'h8000));
    // green goes negative and clamps
    queue_word(eval_known(16'h0000, 16'h0000, 16'h0000, 4096, 0, 0));
    queue_word(write_word(CH_BLUE, BT_Z3, 16'h8000));
    // blue overflows and saturates
    queue_word(eval_known(16'h0000, 16'h0000, 16'h8000, 4096, 0, 16'hFFFF));
    queue_word(eval_word(16'h0000, 16'h0000, 16'h7FFF));
    queue_word(write_word(CH_RED, BT_X3, 16'h7FFF));
    queue_word(write_word(CH_GREEN, BT_Y3, 16'hFFFF));
    queue_word(write_word(CH_BLUE, BT_ONE, 16'h7FFF));
    queue_word(write_word(CH_RED, BT_XYZ, 16'h8000));
    queue_word(write_word(CH_GREEN, BT_X2Y2, 16'h0001));
    queue_word(write_word(CH_BLUE, BT_ZX2Y2, 16'h5555));
    queue_word(eval_word(16'h7FFF, 16'h7FFF, 16'h7FFF));
    queue_word(eval_word(16'h8000, 16'h8000, 16'h8000));
    queue_word(eval_word(16'h8000, 16'h0000, 16'h0000));
    queue_word(eval_word(16'h0000, 16'h8000, 16'h0000));
    queue_word(eval_word(16'h0001, 16'hFFFF, 16'h4000));
    queue_word(write_word(CH_GREEN, BT_ONE, 16'h7FFF));
    queue_word(eval_word(16'h7FFF, 16'h8000, 16'h0000));
    queue_word(write_word(CH_BLUE, BT_Z2, 16'h2AAA));

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_words[i])
      send(directed_words[i]);
    wait_drained();

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 150 == 0)
        calm <= ($urandom_range(0, 3) == 0);
      // hold off until every result is back
      if (n == RANDOM_WORDS / 2)
        wait_drained();
      send(random_word());
    end
    in_valid_i <= 1'b0;

    guard = 0;
    while (pending_rgb.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_rgb.size() != 0) begin
      $error("%0d result words never arrived", pending_rgb.size());
      mismatches++;
    end

    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
